### rtl/dtt_pkg.sv
// Shared constants, codes and types of the deadline timer table.
`timescale 1ns / 1ps

package dtt_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int MAX_POP = 16;
  localparam int POP_W   = 5;
  localparam int TIME_W  = 48;
  localparam int ID_W    = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_POLL   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  localparam logic [STAT_W-1:0] STAT_INSERTED     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_CANCELLED    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_PENDING  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EXPIRED      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NONE_EXPIRED = 3'd4;
  localparam logic [STAT_W-1:0] STAT_FULL         = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   id;
  } ram_wr_t;

endpackage

### rtl/dtt_if.sv
// Request and response channel interfaces of the deadline timer table.
`timescale 1ns / 1ps

interface dtt_req_if;
  import dtt_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [TIME_W-1:0] deadline_ms;
  logic [ID_W-1:0]   cancel_id;
  logic [TIME_W-1:0] now_ms;
  logic [POP_W-1:0]  max_count;

  modport source (output valid, opcode, deadline_ms, cancel_id, now_ms, max_count,
                  input ready);
  modport sink (input valid, opcode, deadline_ms, cancel_id, now_ms, max_count,
                output ready);
endinterface

interface dtt_rsp_if;
  import dtt_pkg::*;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   timer_id;
  logic [STAT_W-1:0] status;
  logic [TIME_W-1:0] next_wait_ms;
  logic              last;

  modport source (output valid, timer_id, status, next_wait_ms, last, input ready);
  modport sink (input valid, timer_id, status, next_wait_ms, last, output ready);
endinterface

### rtl/dtt_table_ram.sv
// Timer table storage: deadline and id per slot, one write and one registered read.
`timescale 1ns / 1ps

module dtt_table_ram (
  input  logic                      clk_i,
  input  dtt_pkg::ram_wr_t          wr_i,
  input  logic                      rd_en_i,
  input  logic [dtt_pkg::IDX_W-1:0] rd_addr_i,
  output logic [dtt_pkg::TIME_W-1:0] rd_deadline_o,
  output logic [dtt_pkg::ID_W-1:0]  rd_id_o
);
  import dtt_pkg::*;

  logic [TIME_W-1:0] deadline_mem [DEPTH];
  logic [ID_W-1:0]   id_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      deadline_mem[wr_i.addr] <= wr_i.deadline;
      id_mem[wr_i.addr]       <= wr_i.id;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_deadline_o <= deadline_mem[rd_addr_i];
      rd_id_o       <= id_mem[rd_addr_i];
    end
  end

endmodule

### rtl/deadline_timer_table.sv
// Deadline timer table: insert, cancel and poll of pending timers over one table scan unit.
// Each scan reads the table one slot a cycle, then the decide state acts on what it found.
// Insert and cancel give their result after one scan.
// A poll handing out n timers runs n + 1 scans; a result that waits on the receiver holds up
// the next scan of the poll and its last result.
// A new request is taken only when the previous one is finished; reset empties the table.
`timescale 1ns / 1ps

module deadline_timer_table (
  input  logic     clk_i,
  input  logic     rst_ni,
  dtt_req_if.sink   req_i,
  dtt_rsp_if.source rsp_o
);
  import dtt_pkg::*;

  state_e state_q, state_d;

  logic [OP_W-1:0]   op_q;
  logic [TIME_W-1:0] dl_q;
  logic [ID_W-1:0]   cid_q;
  logic [TIME_W-1:0] now_q;
  logic [POP_W-1:0]  limit_q;
  logic [POP_W-1:0]  pop_cnt_q;
  logic [ID_W-1:0]   next_id_q;
  logic [DEPTH-1:0]  valid_q;
  logic [CNT_W-1:0]  scan_cnt_q;
  logic              pipe_vld_q;
  logic [IDX_W-1:0]  pipe_slot_q;
  logic              best_found_q;
  logic [TIME_W-1:0] best_dl_q;
  logic [ID_W-1:0]   best_id_q;
  logic [IDX_W-1:0]  best_slot_q;
  logic              pend_q;
  logic [ID_W-1:0]   pend_id_q;

  logic              out_vld_q;
  logic [ID_W-1:0]   out_id_q;
  logic [STAT_W-1:0] out_st_q;
  logic [TIME_W-1:0] out_wait_q;
  logic              out_last_q;

  logic              req_fire;
  logic              out_free;
  logic              scan_done;
  logic              scan_issue;
  logic              scan_start;
  logic              emit;
  logic              grab;
  logic              ins_commit;
  logic              can_commit;
  logic              expire;
  logic              hit;
  logic [ID_W-1:0]   o_id;
  logic [STAT_W-1:0] o_st;
  logic [TIME_W-1:0] o_wait;
  logic              o_last;
  logic [TIME_W-1:0] wait_val;
  logic [ID_W-1:0]   id_inc;
  logic [POP_W-1:0]  limit_in;
  logic [TIME_W-1:0] rd_dl;
  logic [ID_W-1:0]   rd_id;
  ram_wr_t           ram_wr;

  assign req_fire  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign out_free  = !out_vld_q || rsp_o.ready;
  assign scan_done = (scan_cnt_q == CNT_W'(DEPTH)) && !pipe_vld_q;
  assign expire    = best_found_q && (best_dl_q <= now_q) && (pop_cnt_q < limit_q);
  assign wait_val  = !best_found_q ? {TIME_W{1'b1}} :
                     (best_dl_q > now_q) ? (best_dl_q - now_q) : '0;
  assign id_inc    = next_id_q + ID_W'(1);
  assign limit_in  = (req_i.max_count > POP_W'(MAX_POP)) ? POP_W'(MAX_POP) : req_i.max_count;

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.timer_id     = out_id_q;
  assign rsp_o.status       = out_st_q;
  assign rsp_o.next_wait_ms = out_wait_q;
  assign rsp_o.last         = out_last_q;

  assign ram_wr.en       = ins_commit;
  assign ram_wr.addr     = best_slot_q;
  assign ram_wr.deadline = dl_q;
  assign ram_wr.id       = next_id_q;

  dtt_table_ram u_ram (
    .clk_i         (clk_i),
    .wr_i          (ram_wr),
    .rd_en_i       (scan_issue),
    .rd_addr_i     (scan_cnt_q[IDX_W-1:0]),
    .rd_deadline_o (rd_dl),
    .rd_id_o       (rd_id)
  );

  always_comb begin
    hit = 1'b0;
    if (pipe_vld_q) begin
      case (op_q)
        OP_INSERT: hit = !best_found_q && !valid_q[pipe_slot_q];
        OP_CANCEL: hit = !best_found_q && valid_q[pipe_slot_q] && (rd_id == cid_q);
        OP_POLL:   hit = valid_q[pipe_slot_q] &&
                         (!best_found_q || (rd_dl < best_dl_q) ||
                          ((rd_dl == best_dl_q) && (rd_id < best_id_q)));
        default:   hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire && (req_i.opcode != OP_NOP)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (op_q == OP_POLL && expire) begin
          if (!pend_q || out_free) begin
            state_d = ST_SCAN;
          end
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_issue = 1'b0;
    scan_start = 1'b0;
    emit       = 1'b0;
    grab       = 1'b0;
    ins_commit = 1'b0;
    can_commit = 1'b0;
    o_id       = '0;
    o_st       = STAT_NONE_EXPIRED;
    o_wait     = '0;
    o_last     = 1'b0;
    case (state_q)
      ST_IDLE: scan_start = req_fire && (req_i.opcode != OP_NOP);
      ST_SCAN: scan_issue = (scan_cnt_q != CNT_W'(DEPTH));
      ST_DECIDE: begin
        case (op_q)
          OP_INSERT: begin
            if (out_free) begin
              emit   = 1'b1;
              o_last = 1'b1;
              if (best_found_q) begin
                ins_commit = 1'b1;
                o_id       = next_id_q;
                o_st       = STAT_INSERTED;
              end else begin
                o_st = STAT_FULL;
              end
            end
          end
          OP_CANCEL: begin
            if (out_free) begin
              emit   = 1'b1;
              o_last = 1'b1;
              if (best_found_q) begin
                can_commit = 1'b1;
                o_st       = STAT_CANCELLED;
              end else begin
                o_st = STAT_NOT_PENDING;
              end
            end
          end
          OP_POLL: begin
            if (expire) begin
              if (!pend_q || out_free) begin
                grab       = 1'b1;
                scan_start = 1'b1;
                if (pend_q) begin
                  emit = 1'b1;
                  o_id = pend_id_q;
                  o_st = STAT_EXPIRED;
                end
              end
            end else if (out_free) begin
              emit   = 1'b1;
              o_last = 1'b1;
              o_wait = wait_val;
              if (pend_q) begin
                o_id = pend_id_q;
                o_st = STAT_EXPIRED;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_NOP;
      pop_cnt_q    <= '0;
      limit_q      <= '0;
      next_id_q    <= ID_W'(1);
      valid_q      <= '0;
      scan_cnt_q   <= '0;
      pipe_vld_q   <= 1'b0;
      best_found_q <= 1'b0;
      pend_q       <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_fire) begin
        op_q      <= req_i.opcode;
        limit_q   <= limit_in;
        pop_cnt_q <= '0;
        pend_q    <= 1'b0;
      end
      if (scan_start) begin
        scan_cnt_q   <= '0;
        pipe_vld_q   <= 1'b0;
        best_found_q <= 1'b0;
      end else begin
        pipe_vld_q <= scan_issue;
        if (scan_issue) begin
          scan_cnt_q <= scan_cnt_q + CNT_W'(1);
        end
        if (hit) begin
          best_found_q <= 1'b1;
        end
      end
      if (ins_commit) begin
        valid_q[best_slot_q] <= 1'b1;
        next_id_q            <= (id_inc == '0) ? ID_W'(1) : id_inc;
      end
      if (can_commit || grab) begin
        valid_q[best_slot_q] <= 1'b0;
      end
      if (grab) begin
        pend_q    <= 1'b1;
        pop_cnt_q <= pop_cnt_q + POP_W'(1);
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      dl_q  <= req_i.deadline_ms;
      cid_q <= req_i.cancel_id;
      now_q <= req_i.now_ms;
    end
    if (scan_issue) begin
      pipe_slot_q <= scan_cnt_q[IDX_W-1:0];
    end
    if (hit && !scan_start) begin
      best_slot_q <= pipe_slot_q;
      best_dl_q   <= rd_dl;
      best_id_q   <= rd_id;
    end
    if (grab) begin
      pend_id_q <= best_id_q;
    end
    if (emit) begin
      out_id_q   <= o_id;
      out_st_q   <= o_st;
      out_wait_q <= o_wait;
      out_last_q <= o_last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_cnt_q <= limit_q)
    else $error("More timers handed out than the poll limit allows.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) next_id_q != '0)
    else $error("The id counter holds zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ram_wr.en |-> !valid_q[ram_wr.addr])
    else $error("An insert overwrote a pending timer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (rsp_o.valid && !rsp_o.last) |-> (rsp_o.status == STAT_EXPIRED))
    else $error("A non-final result is not an expired entry.");

endmodule
